/* rtl/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and port-level constants for the sequence loss monitor.
// ----------------------------------------------------------------------------
package slm_pkg;

    // Field widths fixed by the stream ports
    localparam int SEQ_PORT_W  = 64;
    localparam int CNT_PORT_W  = 32;
    localparam int NUM_CNT     = 7;
    localparam int S_TDATA_W   = 2 * SEQ_PORT_W;
    localparam int M_TDATA_W   = NUM_CNT * CNT_PORT_W + SEQ_PORT_W;
    localparam int S_TUSER_W   = 2;
    localparam int M_TUSER_W   = 2;

    // Bit positions inside tuser
    localparam int S_TUSER_PRESENT = 0;
    localparam int S_TUSER_VALID   = 1;
    localparam int M_TUSER_FOUND   = 0;
    localparam int M_TUSER_CACHED  = 1;

    // Per-item classification handed from front to back
    typedef struct packed {
        logic inc_total;
        logic inc_valid;
        logic inc_invalid;
        logic inc_msg;
        logic inc_skip;
        logic found;
        logic cached;
        logic last;
    } slm_flags_t;

endpackage

/* rtl/sequence_loss_monitor_top.sv */
// ----------------------------------------------------------------------------
// sequence_loss_monitor_top
// Frame sequence gap and loss counter with per-batch frame choice.
//
//   channel   dir  tdata                                  tuser           tlast
//   s_*       in   frame_number, message_number           present, valid  batch_last
//   m_*       out  total, valid, invalid, lost_frames,    found, cached   batch_done
//                  message_count, lost_messages,
//                  skipped, chosen_number
//
// One transaction per clock in each direction while m_tready holds; a result
// passes from the classifier into a 2-entry queue, then through the counter
// stage into the output register.
// Reset clears all counters, expected numbers and the batch choice.
// Output stalls back up through the queue; s_tready drops only when it is full.
// ----------------------------------------------------------------------------
module sequence_loss_monitor_top
    import slm_pkg::*;
#(
    parameter int COUNTER_WIDTH  = 32,
    parameter int SEQUENCE_WIDTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // frame_number, message_number
    input  logic [S_TUSER_W-1:0] s_tuser,   // frame_present, sample_valid
    input  logic                 s_tlast,   // batch_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // total_count, valid_count, invalid_count,
                                            // lost_frames, message_count, lost_messages,
                                            // skipped_count, chosen_number
    output logic [M_TUSER_W-1:0] m_tuser,   // chosen_found, chosen_cached
    output logic                 m_tlast    // batch_done
);

    localparam int CW      = COUNTER_WIDTH;
    localparam int SW      = SEQUENCE_WIDTH;
    localparam int FLAGS_W = $bits(slm_flags_t);
    localparam int ENTRY_W = FLAGS_W + 2 * CW + SW;

    logic               s_accept;
    slm_flags_t         f_flags, b_flags;
    logic [CW-1:0]      f_fgap, f_mgap, b_fgap, b_mgap;
    logic [SW-1:0]      f_chosen, b_chosen;
    logic [ENTRY_W-1:0] q_in, q_out;
    logic               q_full, q_valid, q_pop;

    logic [CNT_PORT_W-1:0] total_count, valid_count, invalid_count, lost_frames;
    logic [CNT_PORT_W-1:0] message_count, lost_messages, skipped_count;
    logic [SEQ_PORT_W-1:0] chosen_number;
    logic                  chosen_found, chosen_cached;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    slm_front #(
        .COUNTER_WIDTH  (CW),
        .SEQUENCE_WIDTH (SW)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_accept),
        .frame_present  (s_tuser[S_TUSER_PRESENT]),
        .sample_valid   (s_tuser[S_TUSER_VALID]),
        .frame_number   (s_tdata[SEQ_PORT_W-1:0]),
        .message_number (s_tdata[S_TDATA_W-1:SEQ_PORT_W]),
        .batch_last     (s_tlast),
        .flags          (f_flags),
        .frame_gap      (f_fgap),
        .msg_gap        (f_mgap),
        .chosen         (f_chosen)
    );

    assign q_in = {f_chosen, f_mgap, f_fgap, f_flags};

    slm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    assign {b_chosen, b_mgap, b_fgap, b_flags} = q_out;

    slm_back #(
        .COUNTER_WIDTH  (CW),
        .SEQUENCE_WIDTH (SW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (q_valid),
        .in_pop        (q_pop),
        .flags         (b_flags),
        .frame_gap     (b_fgap),
        .msg_gap       (b_mgap),
        .chosen        (b_chosen),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .total_count   (total_count),
        .valid_count   (valid_count),
        .invalid_count (invalid_count),
        .lost_frames   (lost_frames),
        .message_count (message_count),
        .lost_messages (lost_messages),
        .skipped_count (skipped_count),
        .chosen_number (chosen_number),
        .chosen_found  (chosen_found),
        .chosen_cached (chosen_cached),
        .batch_done    (m_tlast)
    );

    assign m_tdata = {chosen_number, skipped_count, lost_messages, message_count,
                      lost_frames, invalid_count, valid_count, total_count};
    assign m_tuser = {chosen_cached, chosen_found};

    // Cached choice is always a found choice
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chosen_cached |-> chosen_found)
        else $error("cached result without found flag");

    // A choice is reported only at batch end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chosen_found |-> m_tlast)
        else $error("frame choice outside batch end");

    // Backpressure on input only when the queue holds entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("input stalled with empty queue");

    // A queued entry is drained whenever the output slot is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !m_tvalid |-> q_pop)
        else $error("queue not drained into free output slot");

endmodule

/* rtl/slm_front.sv */
// ----------------------------------------------------------------------------
// slm_front
// Classifies each accepted descriptor: sequence gaps, batch choice, flags.
// ----------------------------------------------------------------------------
module slm_front
    import slm_pkg::*;
#(
    parameter int COUNTER_WIDTH  = 32,
    parameter int SEQUENCE_WIDTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic                      frame_present,
    input  logic                      sample_valid,
    input  logic [SEQ_PORT_W-1:0]     frame_number,
    input  logic [SEQ_PORT_W-1:0]     message_number,
    input  logic                      batch_last,
    output slm_flags_t                flags,
    output logic [COUNTER_WIDTH-1:0]  frame_gap,
    output logic [COUNTER_WIDTH-1:0]  msg_gap,
    output logic [SEQUENCE_WIDTH-1:0] chosen
);

    localparam int CW = COUNTER_WIDTH;
    localparam int SW = SEQUENCE_WIDTH;
    localparam int GW = (CW > SW) ? CW : SW;

    logic [SW-1:0] exp_frame_reg, exp_frame_next;
    logic [SW-1:0] exp_msg_reg,   exp_msg_next;
    logic [SW-1:0] best_reg,      best_next;
    logic          has_best_reg,  has_best_next;
    logic [SW-1:0] held_reg,      held_next;
    logic          held_vld_reg,  held_vld_next;

    logic [SW-1:0] fnum, mnum;
    logic          is_frame, msg_tracked, take;
    logic          cur_has;
    logic [SW-1:0] cur_best;

    // Zero expected means nothing expected yet; backward step counts one
    function automatic logic [SW-1:0] gap_of(input logic [SW-1:0] exp_v,
                                             input logic [SW-1:0] got);
        logic [SW-1:0] res;
        if (exp_v == '0 || got == exp_v) begin
            res = '0;
        end else if (got > exp_v) begin
            res = got - exp_v;
        end else begin
            res = SW'(1);
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] clamp(input logic [SW-1:0] g);
        logic [CW-1:0] top;
        logic [CW-1:0] res;
        top = '1;
        if (GW'(g) > GW'(top)) begin
            res = top;
        end else begin
            res = CW'(g);
        end
        return res;
    endfunction

    always_comb begin
        fnum        = SW'(frame_number);
        mnum        = SW'(message_number);
        is_frame    = frame_present && sample_valid;
        msg_tracked = is_frame && (mnum != '0);
        take        = !has_best_reg || (fnum > best_reg);

        flags.inc_total   = frame_present;
        flags.inc_valid   = is_frame;
        flags.inc_invalid = frame_present && !sample_valid;
        flags.inc_msg     = msg_tracked;
        flags.inc_skip    = is_frame && !take;
        flags.last        = batch_last;

        frame_gap = is_frame    ? clamp(gap_of(exp_frame_reg, fnum)) : '0;
        msg_gap   = msg_tracked ? clamp(gap_of(exp_msg_reg, mnum))   : '0;

        exp_frame_next = is_frame    ? fnum + SW'(1) : exp_frame_reg;
        exp_msg_next   = msg_tracked ? mnum + SW'(1) : exp_msg_reg;

        cur_has  = has_best_reg || is_frame;
        cur_best = (is_frame && take) ? fnum : best_reg;

        best_next     = cur_best;
        has_best_next = cur_has;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        chosen        = '0;
        flags.found   = 1'b0;
        flags.cached  = 1'b0;

        if (batch_last) begin
            if (cur_has) begin
                chosen        = cur_best;
                flags.found   = 1'b1;
                held_next     = cur_best;
                held_vld_next = 1'b1;
            end else if (held_vld_reg) begin
                chosen       = held_reg;
                flags.found  = 1'b1;
                flags.cached = 1'b1;
            end
            best_next     = '0;
            has_best_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_frame_reg <= '0;
            exp_msg_reg   <= '0;
            best_reg      <= '0;
            has_best_reg  <= 1'b0;
            held_reg      <= '0;
            held_vld_reg  <= 1'b0;
        end else if (accept) begin
            exp_frame_reg <= exp_frame_next;
            exp_msg_reg   <= exp_msg_next;
            best_reg      <= best_next;
            has_best_reg  <= has_best_next;
            held_reg      <= held_next;
            held_vld_reg  <= held_vld_next;
        end
    end

endmodule

/* rtl/slm_queue.sv */
// ----------------------------------------------------------------------------
// slm_queue
// Two-entry FIFO between the classifier and the counter stage.
// ----------------------------------------------------------------------------
module slm_queue
    import slm_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;

    assign full      = (count_reg == 2'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/slm_back.sv */
// ----------------------------------------------------------------------------
// slm_back
// Saturating counters and the result output register.
// ----------------------------------------------------------------------------
module slm_back
    import slm_pkg::*;
#(
    parameter int COUNTER_WIDTH  = 32,
    parameter int SEQUENCE_WIDTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_pop,
    input  slm_flags_t                flags,
    input  logic [COUNTER_WIDTH-1:0]  frame_gap,
    input  logic [COUNTER_WIDTH-1:0]  msg_gap,
    input  logic [SEQUENCE_WIDTH-1:0] chosen,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CNT_PORT_W-1:0]     total_count,
    output logic [CNT_PORT_W-1:0]     valid_count,
    output logic [CNT_PORT_W-1:0]     invalid_count,
    output logic [CNT_PORT_W-1:0]     lost_frames,
    output logic [CNT_PORT_W-1:0]     message_count,
    output logic [CNT_PORT_W-1:0]     lost_messages,
    output logic [CNT_PORT_W-1:0]     skipped_count,
    output logic [SEQ_PORT_W-1:0]     chosen_number,
    output logic                      chosen_found,
    output logic                      chosen_cached,
    output logic                      batch_done
);

    localparam int CW = COUNTER_WIDTH;

    logic [CW-1:0] total_reg,    total_next;
    logic [CW-1:0] valid_reg,    valid_next;
    logic [CW-1:0] invalid_reg,  invalid_next;
    logic [CW-1:0] lost_f_reg,   lost_f_next;
    logic [CW-1:0] msg_reg,      msg_next;
    logic [CW-1:0] lost_m_reg,   lost_m_next;
    logic [CW-1:0] skip_reg,     skip_next;

    logic                  out_valid_reg;
    logic [CNT_PORT_W-1:0] total_o_reg, valid_o_reg, invalid_o_reg, lost_f_o_reg;
    logic [CNT_PORT_W-1:0] msg_o_reg, lost_m_o_reg, skip_o_reg;
    logic [SEQ_PORT_W-1:0] chosen_o_reg;
    logic                  found_o_reg, cached_o_reg, last_o_reg;

    // a + b, clipped to all ones on carry out
    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
    endfunction

    assign in_pop = in_valid && (!out_valid_reg || out_ready);

    always_comb begin
        total_next   = sat_add(total_reg,   CW'(flags.inc_total));
        valid_next   = sat_add(valid_reg,   CW'(flags.inc_valid));
        invalid_next = sat_add(invalid_reg, CW'(flags.inc_invalid));
        lost_f_next  = sat_add(lost_f_reg,  frame_gap);
        msg_next     = sat_add(msg_reg,     CW'(flags.inc_msg));
        lost_m_next  = sat_add(lost_m_reg,  msg_gap);
        skip_next    = sat_add(skip_reg,    CW'(flags.inc_skip));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            valid_reg     <= '0;
            invalid_reg   <= '0;
            lost_f_reg    <= '0;
            msg_reg       <= '0;
            lost_m_reg    <= '0;
            skip_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_pop) begin
                total_reg     <= total_next;
                valid_reg     <= valid_next;
                invalid_reg   <= invalid_next;
                lost_f_reg    <= lost_f_next;
                msg_reg       <= msg_next;
                lost_m_reg    <= lost_m_next;
                skip_reg      <= skip_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_pop) begin
            total_o_reg   <= CNT_PORT_W'(total_next);
            valid_o_reg   <= CNT_PORT_W'(valid_next);
            invalid_o_reg <= CNT_PORT_W'(invalid_next);
            lost_f_o_reg  <= CNT_PORT_W'(lost_f_next);
            msg_o_reg     <= CNT_PORT_W'(msg_next);
            lost_m_o_reg  <= CNT_PORT_W'(lost_m_next);
            skip_o_reg    <= CNT_PORT_W'(skip_next);
            chosen_o_reg  <= SEQ_PORT_W'(chosen);
            found_o_reg   <= flags.found;
            cached_o_reg  <= flags.cached;
            last_o_reg    <= flags.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign total_count   = total_o_reg;
    assign valid_count   = valid_o_reg;
    assign invalid_count = invalid_o_reg;
    assign lost_frames   = lost_f_o_reg;
    assign message_count = msg_o_reg;
    assign lost_messages = lost_m_o_reg;
    assign skipped_count = skip_o_reg;
    assign chosen_number = chosen_o_reg;
    assign chosen_found  = found_o_reg;
    assign chosen_cached = cached_o_reg;
    assign batch_done    = last_o_reg;

endmodule
